// ===== rtl/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants for the batch gradient descent trainer
// Batch size, register indexes and reset values, sequencer states and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // Batch size must be a power of two: the average is an arithmetic shift.
  localparam int BATCH_SIZE  = 4;
  localparam int BATCH_SHIFT = $clog2(BATCH_SIZE);
  localparam int CNT_W       = (BATCH_SIZE > 2) ? $clog2(BATCH_SIZE) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WEIGHT_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WEIGHT_B = 2'd2;

  localparam logic [15:0] LR_RESET     = 16'd6554;
  localparam logic [31:0] INIT_A_RESET = 32'd262144;
  localparam logic [31:0] INIT_B_RESET = 32'd196608;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_PRED,
    S_ERR,
    S_GA,
    S_GB,
    S_ACCB,
    S_UPD_LO,
    S_UPD_HI,
    S_UPD_SUM,
    S_UPD_W,
    S_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) begin
      sat48 = 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      sat48 = 48'sh8000_0000_0000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

// ===== rtl/bgd_if.sv =====
// ----------------------------------------------------------------------------
// bgd_if: valid/ready channels of the batch gradient descent trainer
// Sample channel (two features and a target) and result channel (weights
// and batch number).
// ----------------------------------------------------------------------------
interface bgd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature_a;
  logic signed [15:0] feature_b;
  logic signed [15:0] target;

  modport source (output valid, output feature_a, output feature_b, output target,
                  input ready);
  modport sink   (input valid, input feature_a, input feature_b, input target,
                  output ready);
endinterface

interface bgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight_a_out;
  logic signed [31:0] weight_b_out;
  logic        [15:0] batch_number;

  modport source (output valid, output weight_a_out, output weight_b_out,
                  output batch_number, input ready);
  modport sink   (input valid, input weight_a_out, input weight_b_out,
                  input batch_number, output ready);
endinterface

// ===== rtl/bgd_mul.sv =====
// ----------------------------------------------------------------------------
// bgd_mul: shared signed multiplier with registered product
// One 33x17 signed product per cycle; the product is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module bgd_mul (
  input  logic                                clk_i,
  input  logic signed [bgd_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [bgd_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [bgd_pkg::PROD_W-1:0]   prod_o
);

  logic signed [bgd_pkg::PROD_W-1:0] prod_d;
  logic signed [bgd_pkg::PROD_W-1:0] prod_q;

  assign prod_d = bgd_pkg::PROD_W'(a_i) * bgd_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/batch_gradient_descent_linreg.sv =====
// ----------------------------------------------------------------------------
// batch_gradient_descent_linreg: two-weight linear model trained in batches
// Samples (feature_a, feature_b, target, Q8.8) arrive on in_i. Each sample
// adds its squared-error gradients into two 48-bit sums using the weights
// held for the batch. After BATCH_SIZE samples the weights (Q16.16) are
// stepped by learn_rate times the average gradient, saturated, and sent on
// res_o together with the count of finished batches.
// One shared 33x17 multiplier does every product, so a sample occupies the
// datapath from S_PA to S_ACCB and in_i.ready returns only in S_IDLE: a new
// sample is not taken before the last is through. The last sample of a batch
// then runs S_UPD_LO..S_UPD_W per weight and S_OUT for the result load.
// The result sits in an output register; the next sample is accepted while
// it waits. If the previous result is still untaken when a new one is due,
// the sequencer holds until res_o.ready.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) must go in while idle,
// unchecked by the block; writing an initial weight replaces that weight at once.
// Reset sets learn_rate 0.1, weights 4.0 and 3.0, clears the sums, the
// sample count and the batch count, and drops res_o.valid.
// ----------------------------------------------------------------------------
module batch_gradient_descent_linreg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  bgd_in_if.sink                               in_i,
  bgd_out_if.source                            res_o
);

  bgd_pkg::state_e state_q, state_d;

  logic        [15:0]               lr_q;
  logic signed [31:0]               wa_q, wa_d;
  logic signed [31:0]               wb_q, wb_d;
  logic signed [47:0]               sum_a_q, sum_a_d;
  logic signed [47:0]               sum_b_q, sum_b_d;
  logic        [bgd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic        [15:0]               batches_q, batches_d;
  logic                             lane_q, lane_d;

  logic signed [15:0]               x1_q, x2_q, y_q;
  logic signed [47:0]               acc_q, acc_d;
  logic signed [31:0]               err_q, err_d;

  logic                             out_valid_q, out_valid_d;
  logic signed [31:0]               out_wa_q, out_wb_q;
  logic        [15:0]               out_bn_q;

  logic signed [bgd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bgd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bgd_pkg::PROD_W-1:0]  prod;

  logic                             in_take;
  logic                             out_load;
  logic                             last_sample;
  logic signed [47:0]               avg;
  logic signed [42:0]               grad2;
  logic signed [63:0]               dsum;
  logic signed [31:0]               w_sel;

  bgd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_take     = in_i.valid && in_i.ready;
  assign out_load    = (state_q == bgd_pkg::S_OUT) && (!out_valid_q || res_o.ready);
  assign last_sample = (cnt_q == bgd_pkg::CNT_W'(bgd_pkg::BATCH_SIZE - 1));
  assign avg         = (lane_q ? sum_b_q : sum_a_q) >>> bgd_pkg::BATCH_SHIFT;
  assign grad2       = {prod[bgd_pkg::PROD_W-1:8], 1'b0};
  assign dsum        = (64'(prod) <<< 24) + 64'(acc_q);
  assign w_sel       = lane_q ? wb_q : wa_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bgd_pkg::S_IDLE:    if (in_i.valid) state_d = bgd_pkg::S_PA;
      bgd_pkg::S_PA:      state_d = bgd_pkg::S_PB;
      bgd_pkg::S_PB:      state_d = bgd_pkg::S_PRED;
      bgd_pkg::S_PRED:    state_d = bgd_pkg::S_ERR;
      bgd_pkg::S_ERR:     state_d = bgd_pkg::S_GA;
      bgd_pkg::S_GA:      state_d = bgd_pkg::S_GB;
      bgd_pkg::S_GB:      state_d = bgd_pkg::S_ACCB;
      bgd_pkg::S_ACCB:    state_d = last_sample ? bgd_pkg::S_UPD_LO : bgd_pkg::S_IDLE;
      bgd_pkg::S_UPD_LO:  state_d = bgd_pkg::S_UPD_HI;
      bgd_pkg::S_UPD_HI:  state_d = bgd_pkg::S_UPD_SUM;
      bgd_pkg::S_UPD_SUM: state_d = bgd_pkg::S_UPD_W;
      bgd_pkg::S_UPD_W:   state_d = lane_q ? bgd_pkg::S_OUT : bgd_pkg::S_UPD_LO;
      bgd_pkg::S_OUT:     if (out_load) state_d = bgd_pkg::S_IDLE;
      default:            state_d = bgd_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_i.ready  = (state_q == bgd_pkg::S_IDLE);
    mul_a       = '0;
    mul_b       = '0;
    wa_d        = wa_q;
    wb_d        = wb_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    cnt_d       = cnt_q;
    batches_d   = batches_q;
    lane_d      = lane_q;
    acc_d       = acc_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !res_o.ready;
    case (state_q)
      bgd_pkg::S_PA: begin
        mul_a = 33'(wa_q);
        mul_b = 17'(x1_q);
      end
      bgd_pkg::S_PB: begin
        mul_a = 33'(wb_q);
        mul_b = 17'(x2_q);
        acc_d = 48'(signed'(prod[bgd_pkg::PROD_W-1:8]));
      end
      bgd_pkg::S_PRED: begin
        acc_d = acc_q + 48'(signed'(prod[bgd_pkg::PROD_W-1:8]));
      end
      bgd_pkg::S_ERR: begin
        err_d = bgd_pkg::sat32(64'(signed'({y_q, 8'b0})) - 64'(acc_q));
      end
      bgd_pkg::S_GA: begin
        mul_a = 33'(err_q);
        mul_b = 17'(x1_q);
      end
      bgd_pkg::S_GB: begin
        mul_a   = 33'(err_q);
        mul_b   = 17'(x2_q);
        sum_a_d = bgd_pkg::sat48(64'(sum_a_q) - 64'(grad2));
      end
      bgd_pkg::S_ACCB: begin
        sum_b_d = bgd_pkg::sat48(64'(sum_b_q) - 64'(grad2));
        cnt_d   = last_sample ? '0 : cnt_q + 1'b1;
        lane_d  = 1'b0;
      end
      bgd_pkg::S_UPD_LO: begin
        mul_a = {9'b0, avg[23:0]};
        mul_b = {1'b0, lr_q};
      end
      bgd_pkg::S_UPD_HI: begin
        mul_a = 33'(signed'(avg[47:24]));
        mul_b = {1'b0, lr_q};
        acc_d = prod[47:0];
      end
      bgd_pkg::S_UPD_SUM: begin
        acc_d = dsum[63:16];
      end
      bgd_pkg::S_UPD_W: begin
        if (lane_q) begin
          wb_d = bgd_pkg::sat32(64'(w_sel) - 64'(acc_q));
        end else begin
          wa_d = bgd_pkg::sat32(64'(w_sel) - 64'(acc_q));
        end
        lane_d = 1'b1;
      end
      bgd_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          sum_a_d     = '0;
          sum_b_d     = '0;
          batches_d   = batches_q + 16'd1;
        end
      end
      default: begin
      end
    endcase
    if (cfg_we_i && cfg_idx_i == bgd_pkg::REG_INIT_WEIGHT_A) begin
      wa_d = cfg_data_i;
    end
    if (cfg_we_i && cfg_idx_i == bgd_pkg::REG_INIT_WEIGHT_B) begin
      wb_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgd_pkg::S_IDLE;
      lr_q        <= bgd_pkg::LR_RESET;
      wa_q        <= bgd_pkg::INIT_A_RESET;
      wb_q        <= bgd_pkg::INIT_B_RESET;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      cnt_q       <= '0;
      batches_q   <= '0;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      wb_q        <= wb_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      cnt_q       <= cnt_d;
      batches_q   <= batches_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == bgd_pkg::REG_LEARN_RATE) begin
        lr_q <= cfg_data_i[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    err_q <= err_d;
    if (in_take) begin
      x1_q <= in_i.feature_a;
      x2_q <= in_i.feature_b;
      y_q  <= in_i.target;
    end
    if (out_load) begin
      out_wa_q <= wa_q;
      out_wb_q <= wb_q;
      out_bn_q <= batches_q + 16'd1;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.weight_a_out = out_wa_q;
  assign res_o.weight_b_out = out_wb_q;
  assign res_o.batch_number = out_bn_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgd_pkg::S_OUT) |-> lane_q)
    else $error("result stage reached before both weights were updated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_a_q == '0 && sum_b_q == '0 && cnt_q == '0))
    else $error("gradient sums not cleared after a batch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (batches_q == $past(batches_q) + 16'd1 && res_o.batch_number == batches_q))
    else $error("batch number out of step with the result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgd_pkg::S_ACCB && !last_sample) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("sample count did not advance");

endmodule
